@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, held off while reset is low.
`define BSM_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("bsm assertion failed");

// Concurrent check that also runs during reset.
`define BSM_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("bsm assertion failed");

`endif

@@ rtl/bsm_pkg.sv @@
`default_nettype none

package bsm_pkg;

	localparam int unsigned PRG_RAM_DEPTH_DEF = 8192;

	typedef enum logic [1:0] {
		FUNC_CPU_RD = 2'd0,
		FUNC_CPU_WR = 2'd1,
		FUNC_PPU_RD = 2'd2,
		FUNC_TICK   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		TGT_NONE    = 3'd0,
		TGT_PRG_ROM = 3'd1,
		TGT_PRG_RAM = 3'd2,
		TGT_CHR_ROM = 3'd3,
		TGT_RAM_OFF = 3'd4
	} target_t;

	// Configuration register indexes
	localparam logic CFG_PRG_COUNT = 1'b0;
	localparam logic CFG_CHR_COUNT = 1'b1;

	// Commands carried out by writes to the $A000 window
	localparam logic [3:0] CMD_PRG_RAMWIN = 4'h8;
	localparam logic [3:0] CMD_MIRROR     = 4'hC;
	localparam logic [3:0] CMD_IRQ_CTRL   = 4'hD;
	localparam logic [3:0] CMD_COUNT_LO   = 4'hE;
	localparam logic [3:0] CMD_COUNT_HI   = 4'hF;

	// CPU address windows, by bus_addr[15:13]
	localparam logic [2:0] WIN_PRG_RAM = 3'b011;
	localparam logic [2:0] WIN_CMD_SEL = 3'b100;
	localparam logic [2:0] WIN_CMD_DAT = 3'b101;
	localparam logic [2:0] WIN_CHR     = 3'b000;

	typedef struct packed {
		logic        handled;
		target_t     target;
		logic [18:0] rom_address;
		logic        ram_rd;
		logic [1:0]  mirror_mode;
		logic        irq_fire;
	} res_t;

endpackage

`default_nettype wire

@@ rtl/bsm_ram.sv @@
`default_nettype none

module bsm_ram
	import bsm_pkg::*;
#(
	parameter int unsigned DEPTH = PRG_RAM_DEPTH_DEF,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read data is registered and holds when no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/bank_switch_mapper_irq_unit.sv @@
// An accepted word is registered in result stage s1, then in the output register.
// Throughput: one word per cycle while in_stall is low (no clearing pass and no
// out_stall back-pressure); set by the single decode stage and the one write and
// one read port of the PRG RAM, with a result stage and an output stage.
// Reset: control state takes its reset values at once; then the PRG RAM is cleared
// one byte per cycle over PRG_RAM_DEPTH (default 8192) bytes, with in_stall high.
`default_nettype none

`include "assert_macros.svh"

module bank_switch_mapper_irq_unit
	import bsm_pkg::*;
#(
	parameter int unsigned PRG_RAM_DEPTH = PRG_RAM_DEPTH_DEF,
	localparam int unsigned AW = $clog2(PRG_RAM_DEPTH)
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [5:0]  cfg_wdata,

	// input words
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [15:0] bus_addr,
	input  wire logic [7:0]  write_data,
	input  wire logic [7:0]  tick_cycles,

	// result words
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             handled,
	output logic [2:0]       target,
	output logic [18:0]      rom_address,
	output logic [7:0]       ram_read_data,
	output logic [1:0]       mirror_mode,
	output logic             irq_fire
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [5:0] prg_count_q;
	logic [5:0] chr_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q <= 6'd1;
			chr_count_q <= 6'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PRG_COUNT: prg_count_q <= cfg_wdata;
				CFG_CHR_COUNT: chr_count_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// PRG mask is count*2-1 in 8K banks and doubles as the last bank; CHR mask
	// is count*8-1 in 1K banks. A zero count wraps to all ones.
	logic [5:0] prg_bank_mask;
	logic [7:0] chr_bank_mask;
	assign prg_bank_mask = {prg_count_q[4:0], 1'b0} - 6'd1;
	assign chr_bank_mask = {chr_count_q[4:0], 3'b000} - 8'd1;

	// ------------------------------------------------------------------
	// Mapper state
	// ------------------------------------------------------------------
	logic [3:0]  cmd_q;
	logic [5:0]  prg_bank_q [4];
	logic [7:0]  chr_bank_q [8];
	logic [15:0] count_q;
	logic        count_on_q;
	logic        irq_on_q;
	logic        ram_sel_q;
	logic        ram_en_q;
	logic [1:0]  mirror_q;

	// PRG RAM clearing pass after reset
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	// Handshake
	logic   valid_s1;
	res_t   res_s1;
	logic   s1_adv;
	logic   in_acc;
	logic   out_valid_q;

	assign s1_adv   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = clr_busy_q || (valid_s1 && !s1_adv);
	assign in_acc   = in_valid && !in_stall;

	// ------------------------------------------------------------------
	// Decode: result and next state for the word at the inputs
	// ------------------------------------------------------------------
	func_t       fn;
	logic [2:0]  win;
	logic [5:0]  rd_bank;
	logic [16:0] cnt_diff;
	logic        ram_wr;
	logic        reg_wr;
	logic        sel_wr;
	res_t        res;

	assign fn       = func_t'(func);
	assign win      = bus_addr[15:13];
	assign cnt_diff = {1'b0, count_q} - {9'd0, tick_cycles};
	assign ram_wr   = (fn == FUNC_CPU_WR) && (win == WIN_PRG_RAM) && ram_sel_q && ram_en_q;
	assign sel_wr   = (fn == FUNC_CPU_WR) && (win == WIN_CMD_SEL);
	assign reg_wr   = (fn == FUNC_CPU_WR) && (win == WIN_CMD_DAT);

	// Bank for a CPU read at $8000 and above; $E000 is pinned to the last bank
	always_comb begin
		case (bus_addr[14:13])
			2'd0:    rd_bank = prg_bank_q[1];
			2'd1:    rd_bank = prg_bank_q[2];
			2'd2:    rd_bank = prg_bank_q[3];
			default: rd_bank = prg_bank_mask;
		endcase
	end

	always_comb begin
		res             = '0;
		res.target      = TGT_NONE;
		res.mirror_mode = mirror_q;
		case (fn)
			FUNC_CPU_RD: begin
				if (win == WIN_PRG_RAM) begin
					res.handled = 1'b1;
					if (ram_sel_q) begin
						if (ram_en_q) begin
							res.target = TGT_PRG_RAM;
							res.ram_rd = 1'b1;
						end else begin
							res.target = TGT_RAM_OFF;
						end
					end else begin
						res.target      = TGT_PRG_ROM;
						res.rom_address = {prg_bank_q[0], bus_addr[12:0]};
					end
				end else if (bus_addr[15]) begin
					res.handled     = 1'b1;
					res.target      = TGT_PRG_ROM;
					res.rom_address = {rd_bank, bus_addr[12:0]};
				end
			end
			FUNC_CPU_WR: begin
				// register writes are not claimed; the RAM window is
				if (win == WIN_PRG_RAM) begin
					res.handled = 1'b1;
					if (ram_sel_q) begin
						res.target = ram_en_q ? TGT_PRG_RAM : TGT_RAM_OFF;
					end
				end
				if (reg_wr && (cmd_q == CMD_MIRROR)) begin
					res.mirror_mode = write_data[1:0];
				end
			end
			FUNC_PPU_RD: begin
				if (win == WIN_CHR) begin
					res.handled     = 1'b1;
					res.target      = TGT_CHR_ROM;
					res.rom_address = {1'b0, chr_bank_q[bus_addr[12:10]], bus_addr[9:0]};
				end
			end
			FUNC_TICK: begin
				res.irq_fire = count_on_q && irq_on_q && cnt_diff[16];
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// State update on each accepted word
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q      <= '0;
			prg_bank_q <= '{default: '0};
			chr_bank_q <= '{default: '0};
			count_q    <= '0;
			count_on_q <= 1'b0;
			irq_on_q   <= 1'b0;
			ram_sel_q  <= 1'b0;
			ram_en_q   <= 1'b0;
			mirror_q   <= 2'd1;
		end else if (in_acc) begin
			if (sel_wr) begin
				cmd_q <= write_data[3:0];
			end
			if (reg_wr) begin
				if (!cmd_q[3]) begin
					chr_bank_q[cmd_q[2:0]] <= write_data & chr_bank_mask;
				end else if (!cmd_q[2]) begin
					prg_bank_q[cmd_q[1:0]] <= write_data[5:0] & prg_bank_mask;
					if (cmd_q == CMD_PRG_RAMWIN) begin
						ram_sel_q <= write_data[6];
						ram_en_q  <= write_data[7];
					end
				end else begin
					case (cmd_q)
						CMD_MIRROR:   mirror_q <= write_data[1:0];
						CMD_IRQ_CTRL: begin
							irq_on_q   <= write_data[0];
							count_on_q <= write_data[7];
						end
						CMD_COUNT_LO: count_q[7:0]  <= write_data;
						CMD_COUNT_HI: count_q[15:8] <= write_data;
						default: ;
					endcase
				end
			end
			// count down, wrapping modulo 65536
			if ((fn == FUNC_TICK) && count_on_q) begin
				count_q <= cnt_diff[15:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// PRG RAM: clearing pass, then CPU writes; reads issued on accept
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(PRG_RAM_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;

	assign ram_we    = clr_busy_q || (in_acc && ram_wr);
	assign ram_waddr = clr_busy_q ? clr_addr_q : bus_addr[AW-1:0];
	assign ram_wdata = clr_busy_q ? 8'd0 : write_data;

	bsm_ram #(
		.DEPTH (PRG_RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_acc),
		.raddr (bus_addr[AW-1:0]),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Result stage, then output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_s1 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	logic        handled_q;
	logic [2:0]  target_q;
	logic [18:0] rom_address_q;
	logic [7:0]  ram_read_data_q;
	logic [1:0]  mirror_mode_q;
	logic        irq_fire_q;

	// ram_rdata only moves on accept, and s1 holds no newer word, so it still
	// belongs to the word in s1 here
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			handled_q       <= res_s1.handled;
			target_q        <= res_s1.target;
			rom_address_q   <= res_s1.rom_address;
			ram_read_data_q <= res_s1.ram_rd ? ram_rdata : 8'd0;
			mirror_mode_q   <= res_s1.mirror_mode;
			irq_fire_q      <= res_s1.irq_fire;
		end
	end

	assign out_valid     = out_valid_q;
	assign handled       = handled_q;
	assign target        = target_q;
	assign rom_address   = rom_address_q;
	assign ram_read_data = ram_read_data_q;
	assign mirror_mode   = mirror_mode_q;
	assign irq_fire      = irq_fire_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`BSM_ASSERT(a_no_accept_clearing, clk, arst_n, clr_busy_q |-> !in_acc)
	`BSM_ASSERT(a_s1_holds, clk, arst_n,
		(valid_s1 && !s1_adv) |=> (valid_s1 && $stable(res_s1)))
	`BSM_ASSERT(a_out_holds, clk, arst_n,
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(rom_address_q)))
	`BSM_ASSERT(a_irq_on_tick_only, clk, arst_n,
		(valid_s1 && res_s1.irq_fire) |-> (!res_s1.handled && res_s1.target == TGT_NONE))

endmodule

`default_nettype wire
